@@ hw/rtl/utf8_stream_decoder_unit_assert.svh @@
// ----------------------------------------------------------------------------
// utf8 stream decoder assertion macros
// concurrent checks on the rising clock edge, masked while reset is high;
// defining ASSERT_OFF leaves every check out
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_UNIT_ASSERT_SVH
`define UTF8_STREAM_DECODER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// property must hold at every edge outside reset
`define UTSD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define UTSD_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define UTSD_ASSERT(lbl, clk, rst, prop, msg)
`define UTSD_ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

@@ hw/rtl/utf8sd_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8 stream decoder package
// widths, byte patterns and the state and result types shared by the decoder
// ----------------------------------------------------------------------------
package utf8sd_pkg;

   // field widths
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CP_W   = 31;
   localparam int unsigned CNT_W  = 3;
   localparam int unsigned LEAD_W = 5;

   // replacement character '?'
   localparam logic [CP_W-1:0] REPL_CHAR = CP_W'(63);

   // continuation byte tag, 10xxxxxx
   localparam logic [1:0] CONT_TAG = 2'b10;

   // lead byte masks and tags for the two- to six-byte forms
   localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'd224;
   localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'd192;
   localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'd240;
   localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'd224;
   localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'd248;
   localparam logic [BYTE_W-1:0] LEAD4_TAG  = 8'd240;
   localparam logic [BYTE_W-1:0] LEAD5_MASK = 8'd252;
   localparam logic [BYTE_W-1:0] LEAD5_TAG  = 8'd248;
   localparam logic [BYTE_W-1:0] LEAD6_MASK = 8'd254;
   localparam logic [BYTE_W-1:0] LEAD6_TAG  = 8'd252;

   // running decoder state
   typedef struct packed {
      logic [CP_W-1:0]  partial;
      logic [CNT_W-1:0] pending;
   } dec_state_type;

   // outcome of one byte
   typedef struct packed {
      logic            emit;
      logic [CP_W-1:0] code_point;
      logic            replaced;
   } step_result_type;

endpackage

@@ hw/rtl/utf8_stream_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// utf8 stream decoder unit
// Decodes a UTF-8 byte stream, old five- and six-byte forms included, into
// 31-bit code points; malformed input gives '?' with rsp_replaced set.
// Input channel: req_data_byte and req_end_of_buffer, transfer on req_valid
// with req_stall low. Result channel: rsp_code_point and rsp_replaced,
// transfer on rsp_valid with rsp_stall low. Lead and middle bytes of a
// sequence give no result unless the buffer ends there; any other gives one.
// Path: a taken byte is held in the input register; its result is loaded
// into the result register, which drives rsp_valid.
// Throughput: one byte per cycle while no byte with a result is held back
// by rsp_stall, set by the combinational decode step between the input and
// result registers.
// Stall: while a result waits under rsp_stall, a byte that needs no result
// still moves on; a byte with a result holds in the input register and
// req_stall rises. Stall propagates back in the same cycle.
// Reset (synchronous, active high) empties both registers and clears the
// partial code point and pending count.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_unit_assert.svh"

module utf8_stream_decoder_unit
   import utf8sd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              req_end_of_buffer,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CP_W-1:0]   rsp_code_point,
   output logic              rsp_replaced
);

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_eob_ff;
   dec_state_type     state_ff;
   dec_state_type     state_in;
   step_result_type   step_res;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic [CP_W-1:0]   out_cp_ff;
   logic              out_repl_ff;
   logic              req_take;
   logic              out_free;
   logic              advance;

   // handshake control
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!step_res.emit || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // decode step
   utf8sd_step u_step (
      .data_byte     (in_byte_ff),
      .end_of_buffer (in_eob_ff),
      .cur_state     (state_ff),
      .nxt_state     (state_in),
      .result        (step_res)
   );

   // input register
   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_eob_ff  <= req_end_of_buffer;
      end
   end

   // running state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_comb begin
      if (advance && step_res.emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance && step_res.emit) begin
         out_cp_ff   <= step_res.code_point;
         out_repl_ff <= step_res.replaced;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_point = out_cp_ff;
   assign rsp_replaced   = out_repl_ff;

   // checks
   `UTSD_ASSERT_NEVER(a_pending_range, clock, reset, state_ff.pending > CNT_W'(5), "pending count above five")
   `UTSD_ASSERT(a_pending_data, clock, reset, (state_ff.pending == '0) || (state_ff.partial != '0), "open sequence with no data bits")
   `UTSD_ASSERT(a_idle_clear, clock, reset, (state_ff.pending != '0) || (state_ff.partial == '0), "partial value left after sequence end")
   `UTSD_ASSERT(a_repl_char, clock, reset, rsp_valid && rsp_replaced |-> rsp_code_point == REPL_CHAR, "replacement is not the question mark")
   `UTSD_ASSERT(a_hold_blocked, clock, reset, in_valid_ff && step_res.emit && out_valid_ff && rsp_stall |=> in_valid_ff && $stable(in_byte_ff), "blocked byte lost from input register")

endmodule

@@ hw/rtl/utf8sd_step.sv @@
// ----------------------------------------------------------------------------
// utf8 stream decoder byte step
// combinational decode of one byte against the running state: gives the next
// state and at most one result
// ----------------------------------------------------------------------------
module utf8sd_step
   import utf8sd_pkg::*;
(
   input  logic [BYTE_W-1:0] data_byte,
   input  logic              end_of_buffer,
   input  dec_state_type     cur_state,
   output dec_state_type     nxt_state,
   output step_result_type   result
);

   logic [CP_W-1:0]   shifted;
   logic [CNT_W-1:0]  cnt_dec;
   logic [LEAD_W-1:0] lead_data;
   logic [CNT_W-1:0]  lead_due;
   logic              lead_ok;

   // continuation path: shift six data bits in
   assign shifted = {cur_state.partial[CP_W-7:0], data_byte[5:0]};
   assign cnt_dec = cur_state.pending - CNT_W'(1);

   // lead byte classification
   always_comb begin
      lead_ok   = 1'b1;
      lead_data = '0;
      lead_due  = '0;
      if ((data_byte & LEAD2_MASK) == LEAD2_TAG) begin
         lead_data = data_byte[4:0];
         lead_due  = CNT_W'(1);
      end else if ((data_byte & LEAD3_MASK) == LEAD3_TAG) begin
         lead_data = LEAD_W'(data_byte[3:0]);
         lead_due  = CNT_W'(2);
      end else if ((data_byte & LEAD4_MASK) == LEAD4_TAG) begin
         lead_data = LEAD_W'(data_byte[2:0]);
         lead_due  = CNT_W'(3);
      end else if ((data_byte & LEAD5_MASK) == LEAD5_TAG) begin
         lead_data = LEAD_W'(data_byte[1:0]);
         lead_due  = CNT_W'(4);
      end else if ((data_byte & LEAD6_MASK) == LEAD6_TAG) begin
         lead_data = LEAD_W'(data_byte[0]);
         lead_due  = CNT_W'(5);
      end else begin
         lead_ok = 1'b0;
      end
   end

   // next state and result
   always_comb begin
      nxt_state = cur_state;
      result    = '{emit: 1'b0, code_point: '0, replaced: 1'b0};
      if (cur_state.pending != '0) begin
         if (data_byte[7:6] != CONT_TAG) begin
            // bad continuation swallowed, sequence dropped
            nxt_state = '0;
            result    = '{emit: 1'b1, code_point: REPL_CHAR, replaced: 1'b1};
         end else if (cnt_dec == '0) begin
            nxt_state = '0;
            result    = '{emit: 1'b1, code_point: shifted, replaced: 1'b0};
         end else if (end_of_buffer) begin
            // buffer ends inside a sequence
            nxt_state = '0;
            result    = '{emit: 1'b1, code_point: REPL_CHAR, replaced: 1'b1};
         end else begin
            nxt_state.partial = shifted;
            nxt_state.pending = cnt_dec;
         end
      end else if (!data_byte[7]) begin
         // plain ascii
         result = '{emit: 1'b1, code_point: CP_W'(data_byte), replaced: 1'b0};
      end else if (!lead_ok || lead_data == '0 || end_of_buffer) begin
         // invalid or empty lead, or no room left for the sequence
         result = '{emit: 1'b1, code_point: REPL_CHAR, replaced: 1'b1};
      end else begin
         nxt_state.partial = CP_W'(lead_data);
         nxt_state.pending = lead_due;
      end
   end

endmodule
